### hdl/battery_pack_supervisor_top_defines.svh
// assertion macros shared by the battery pack supervisor rtl
// needs a clk_i and rst_ni in the scope where a macro is used
`ifndef BATTERY_PACK_SUPERVISOR_TOP_DEFINES_SVH
`define BATTERY_PACK_SUPERVISOR_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define BPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/bps_pkg.sv
// types, codes and constants of the battery pack supervisor
// used by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  localparam int NUM_MODULES_DEF = 24;
  localparam int CELLS_PER_MOD   = 8;
  localparam int NUM_CFG         = 8;
  localparam int CFG_IDX_W       = 3;

  localparam logic [2:0] CFG_CELL_TEMP = 3'd0;
  localparam logic [2:0] CFG_RES_TEMP  = 3'd1;
  localparam logic [2:0] CFG_RES_HARD  = 3'd2;
  localparam logic [2:0] CFG_CELL_MIN  = 3'd3;
  localparam logic [2:0] CFG_CELL_MAX  = 3'd4;
  localparam logic [2:0] CFG_BAL_START = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT   = 3'd6;
  localparam logic [2:0] CFG_PERIOD    = 3'd7;

  localparam logic [15:0] CFG_RESET [NUM_CFG] =
    '{16'd500, 16'd800, 16'd100, 16'd2400, 16'd3650, 16'd3200, 16'd500, 16'd250};

  localparam logic [7:0]  ADDR_BASE   = 8'h11;
  localparam logic [7:0]  RPT_TEMP    = 8'h14;
  localparam logic [7:0]  RPT_CELL_LO = 8'h15;
  localparam logic [7:0]  RPT_CELL_HI = 8'h16;
  localparam logic [7:0]  RPT_STATE_A = 8'h17;
  localparam logic [7:0]  RPT_STATE_B = 8'h1E;
  localparam logic [7:0]  POLL_BASE   = 8'h14;
  localparam logic [15:0] MV_NONE     = 16'hFFFF;

  localparam logic [2:0] MODE_NOCOMM     = 3'd0;
  localparam logic [2:0] MODE_CONNECTING = 3'd1;
  localparam logic [2:0] MODE_MONITOR    = 3'd2;
  localparam logic [2:0] MODE_BALANCE    = 3'd3;
  localparam logic [2:0] MODE_PROBLEM    = 3'd4;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_REPORT = 2'd1,
    FUNC_MODE   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_OPEN   = 3'd0,
    KIND_POLL   = 3'd1,
    KIND_SETBAL = 3'd2,
    KIND_SETMON = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    SET_NONE = 2'd0,
    SET_BAL  = 2'd1,
    SET_MON  = 2'd2
  } set_e;

  typedef struct packed {
    logic load;
    logic mstep;
    logic cstep;
    logic rep1;
    logic rep2;
    logic fin;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  want_bal;
    logic  mdone;
    logic  clast;
    logic  emit_open;
    logic  emit_poll;
    set_e  set_kind;
  } sts_t;

  function automatic logic is_conn(logic [2:0] m);
    return (m != MODE_NOCOMM) && (m != MODE_CONNECTING);
  endfunction

endpackage

`default_nettype wire

### hdl/bps_datapath.sv
// datapath: config registers, module table, cell voltage memory, scan accumulators
// driven by commands from bps_ctrl, uses bps_pkg
`timescale 1ns / 1ps
`default_nettype none

module bps_datapath #(
  parameter int NUM_MODULES = bps_pkg::NUM_MODULES_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  bps_pkg::cmd_t             cmd_i,
  output bps_pkg::sts_t             sts_o,
  input  wire                       cfg_we_i,
  input  wire [bps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [15:0]                cfg_data_i,
  input  wire [1:0]                 func_i,
  input  wire [31:0]                now_ms_i,
  input  wire [7:0]                 source_addr_i,
  input  wire [7:0]                 report_cmd_i,
  input  wire [3:0]                 payload_len_i,
  input  wire [15:0]                word_a_i,
  input  wire [15:0]                word_b_i,
  input  wire [15:0]                word_c_i,
  input  wire                       want_balance_i,
  output logic [7:0]                poll_cmd_o,
  output logic [15:0]               target_mv_o,
  output logic                      error_latched_o,
  output logic [4:0]                connected_o
);
  import bps_pkg::*;

  localparam int IDW   = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam int CW    = IDW + 3;
  localparam int NCELL = NUM_MODULES * CELLS_PER_MOD;

  logic [15:0] cfg_q [NUM_CFG];
  func_e       func_q;
  logic [31:0] now_q;
  logic [7:0]  src_q, rcmd_q;
  logic [3:0]  len_q;
  logic [15:0] wa_q, wb_q, wc_q;
  logic        wbal_q;

  logic [2:0]  mode_q [NUM_MODULES];
  logic [31:0] seen_q [NUM_MODULES];
  logic        cv_q   [NCELL];
  logic [15:0] cell_mem [NCELL];

  logic [15:0] rtmax_q, ctmax_q, tgt_q, mn_q, mx_q, mnc_q, rd_q;
  logic [4:0]  cnt_q, macc_q;
  logic        ffl_q, bal_q, fault_q, eo_q, ep_q, rdv_q, rconn_q, svld_q;
  logic [31:0] opn_q, pnx_q;
  logic [1:0]  pidx_q;
  logic [7:0]  pcmd_q;
  set_e        sk_q;
  logic [IDW-1:0] midx_q;
  logic [CW-1:0]  caddr_q;

  // decode of the held report
  logic [8:0]     src_ext;
  logic           src_ok, grp, state_cmd, hit, mconn, mdone, fault_t;
  logic [IDW-1:0] id, maddr;
  logic [2:0]     off, mrd, newmode;
  logic [16:0]    hard;
  logic [15:0]    ctnew, cval;
  logic           we;
  logic [CW-1:0]  waddr;
  logic [15:0]    wdata;

  assign src_ext   = {1'b0, src_q};
  assign src_ok    = (src_ext >= {1'b0, ADDR_BASE}) &&
                     (src_ext < ({1'b0, ADDR_BASE} + 9'(NUM_MODULES)));
  assign id        = IDW'(src_q - ADDR_BASE);
  assign grp       = src_ok && (((rcmd_q == RPT_CELL_LO) && (len_q >= 4'd6)) ||
                                ((rcmd_q == RPT_CELL_HI) && (len_q >= 4'd2)));
  assign state_cmd = ((rcmd_q == RPT_STATE_A) || (rcmd_q == RPT_STATE_B)) &&
                     (len_q >= 4'd2);
  assign off       = ((rcmd_q == RPT_CELL_HI) ? 3'd4 : 3'd0) +
                     ((wa_q == 16'd0) ? 3'd0 : 3'd2);
  assign hard      = {1'b0, cfg_q[CFG_RES_TEMP]} + {1'b0, cfg_q[CFG_RES_HARD]};
  assign ctnew     = (wc_q > ctmax_q) ? wc_q : ctmax_q;

  // single read port on the module table
  assign maddr   = cmd_i.mstep ? midx_q : (cmd_i.cstep ? caddr_q[CW-1:3] : id);
  assign mrd     = mode_q[maddr];
  assign newmode = (mrd == MODE_NOCOMM) ? MODE_CONNECTING : wa_q[2:0];
  assign hit     = (mrd != MODE_NOCOMM) &&
                   ((seen_q[midx_q] + {16'd0, cfg_q[CFG_TIMEOUT]}) < now_q);
  assign mconn   = is_conn(mrd);
  assign mdone   = cmd_i.mstep && (hit || (midx_q == IDW'(NUM_MODULES - 1)));

  assign cval    = rdv_q ? rd_q : 16'd0;
  assign fault_t = fault_q || ((func_q == FUNC_TICK) &&
                   ((mn_q < cfg_q[CFG_CELL_MIN]) || (mx_q > cfg_q[CFG_CELL_MAX])));

  assign we    = grp && (cmd_i.rep1 || cmd_i.rep2);
  assign waddr = {id, cmd_i.rep2 ? (off | 3'd1) : off};
  assign wdata = cmd_i.rep2 ? wc_q : wb_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      cell_mem[waddr] <= wdata;
    end
    rd_q <= cell_mem[caddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) cfg_q[i] <= CFG_RESET[i];
      for (int i = 0; i < NUM_MODULES; i++) begin
        mode_q[i] <= MODE_NOCOMM;
        seen_q[i] <= 32'd0;
      end
      for (int i = 0; i < NCELL; i++) cv_q[i] <= 1'b0;
      func_q  <= FUNC_NOP;
      rtmax_q <= 16'd0;
      ctmax_q <= 16'd0;
      tgt_q   <= 16'd0;
      cnt_q   <= 5'd0;
      macc_q  <= 5'd0;
      ffl_q   <= 1'b0;
      bal_q   <= 1'b0;
      fault_q <= 1'b0;
      eo_q    <= 1'b0;
      ep_q    <= 1'b0;
      opn_q   <= 32'd0;
      pnx_q   <= 32'd0;
      pidx_q  <= 2'd0;
      pcmd_q  <= 8'd0;
      sk_q    <= SET_NONE;
      midx_q  <= '0;
      caddr_q <= '0;
      rdv_q   <= 1'b0;
      rconn_q <= 1'b0;
      svld_q  <= 1'b0;
      mn_q    <= MV_NONE;
      mx_q    <= 16'd0;
      mnc_q   <= MV_NONE;
    end else begin
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;
      if (we) cv_q[waddr] <= 1'b1;

      rdv_q   <= cv_q[caddr_q];
      rconn_q <= mconn;
      svld_q  <= cmd_i.cstep;
      if (svld_q) begin
        if (cval < mn_q) mn_q <= cval;
        if (cval > mx_q) mx_q <= cval;
        if (rconn_q && (cval < mnc_q)) mnc_q <= cval;
      end

      if (cmd_i.load) begin
        func_q  <= func_e'(func_i);
        fault_q <= 1'b0;
        eo_q    <= 1'b0;
        ep_q    <= 1'b0;
        sk_q    <= SET_NONE;
        midx_q  <= '0;
        macc_q  <= 5'd0;
        caddr_q <= '0;
        mn_q    <= MV_NONE;
        mx_q    <= 16'd0;
        mnc_q   <= MV_NONE;
      end

      if (cmd_i.mstep) begin
        if (hit) begin
          mode_q[midx_q] <= MODE_NOCOMM;
          fault_q        <= 1'b1;
        end
        if (mdone) begin
          cnt_q <= macc_q + 5'((mconn && !hit) ? 1 : 0);
        end else begin
          macc_q <= macc_q + 5'(mconn ? 1 : 0);
          midx_q <= midx_q + 1'b1;
        end
      end

      if (cmd_i.cstep) caddr_q <= caddr_q + 1'b1;

      if (cmd_i.rep1 && src_ok) begin
        seen_q[id] <= now_q;
        if ((rcmd_q == RPT_TEMP) && (len_q >= 4'd2)) begin
          if (rtmax_q < wa_q) begin
            rtmax_q <= wa_q;
            if (wa_q > cfg_q[CFG_RES_TEMP]) begin
              bal_q <= 1'b0;
              if ({1'b0, wa_q} > hard) fault_q <= 1'b1;
            end
          end
        end else if (state_cmd) begin
          mode_q[id] <= newmode;
          if (newmode == MODE_PROBLEM) fault_q <= 1'b1;
          if (!bal_q && (newmode == MODE_BALANCE)) sk_q <= SET_MON;
          else if (bal_q && (newmode == MODE_MONITOR)) sk_q <= SET_BAL;
        end else if (grp && (wa_q == 16'd0)) begin
          ctmax_q <= ctnew;
          if (ctnew > cfg_q[CFG_CELL_TEMP]) fault_q <= 1'b1;
        end
      end

      if (cmd_i.fin) begin
        if (func_q == FUNC_MODE) begin
          if (wbal_q) begin
            if ((mnc_q != MV_NONE) && (mnc_q > cfg_q[CFG_BAL_START])) begin
              tgt_q <= mnc_q;
              bal_q <= 1'b1;
              sk_q  <= SET_BAL;
            end
          end else begin
            bal_q <= 1'b0;
            sk_q  <= SET_MON;
          end
        end
        if (fault_t) begin
          ffl_q <= 1'b1;
          if (opn_q < now_q) begin
            opn_q <= now_q + {16'd0, cfg_q[CFG_PERIOD]};
            eo_q  <= 1'b1;
          end
        end
        if ((func_q == FUNC_TICK) && (pnx_q < now_q)) begin
          pnx_q  <= now_q + {16'd0, cfg_q[CFG_PERIOD]};
          pcmd_q <= POLL_BASE + {6'd0, pidx_q};
          pidx_q <= pidx_q + 2'd1;
          ep_q   <= 1'b1;
        end
      end
    end
  end

  // payload of the held item, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q  <= now_ms_i;
      src_q  <= source_addr_i;
      rcmd_q <= report_cmd_i;
      len_q  <= payload_len_i;
      wa_q   <= word_a_i;
      wb_q   <= word_b_i;
      wc_q   <= word_c_i;
      wbal_q <= want_balance_i;
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.want_bal  = wbal_q;
  assign sts_o.mdone     = mdone;
  assign sts_o.clast     = (caddr_q == CW'(NCELL - 1));
  assign sts_o.emit_open = eo_q;
  assign sts_o.emit_poll = ep_q;
  assign sts_o.set_kind  = sk_q;

  assign poll_cmd_o      = pcmd_q;
  assign target_mv_o     = tgt_q;
  assign error_latched_o = ffl_q;
  assign connected_o     = cnt_q;

endmodule

`default_nettype wire

### hdl/bps_ctrl.sv
// controller state machine: sequences scans, report updates and result words
// issues commands to bps_datapath, uses bps_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "battery_pack_supervisor_top_defines.svh"

module bps_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output bps_pkg::kind_e out_kind_o,
  output bps_pkg::cmd_t  cmd_o,
  input  bps_pkg::sts_t  sts_i
);
  import bps_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_DISP   = 12'b000000000010,
    ST_MSCAN  = 12'b000000000100,
    ST_CSCAN  = 12'b000000001000,
    ST_CDRAIN = 12'b000000010000,
    ST_REP1   = 12'b000000100000,
    ST_REP2   = 12'b000001000000,
    ST_FIN    = 12'b000010000000,
    ST_OOPEN  = 12'b000100000000,
    ST_OPOLL  = 12'b001000000000,
    ST_OSET   = 12'b010000000000,
    ST_OSTAT  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_kind_o  = KIND_STATUS;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts_i.func)
          FUNC_TICK:   state_d = ST_MSCAN;
          FUNC_REPORT: state_d = ST_REP1;
          FUNC_MODE:   state_d = sts_i.want_bal ? ST_CSCAN : ST_FIN;
          default:     state_d = ST_FIN;
        endcase
      end
      ST_MSCAN: begin
        cmd_o.mstep = 1'b1;
        if (sts_i.mdone) state_d = ST_CSCAN;
      end
      ST_CSCAN: begin
        cmd_o.cstep = 1'b1;
        if (sts_i.clast) state_d = ST_CDRAIN;
      end
      // last read word lands in the accumulators here
      ST_CDRAIN: state_d = ST_FIN;
      ST_REP1: begin
        cmd_o.rep1 = 1'b1;
        state_d    = ST_REP2;
      end
      ST_REP2: begin
        cmd_o.rep2 = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_OOPEN;
      end
      ST_OOPEN: begin
        out_valid_o = sts_i.emit_open;
        out_kind_o  = KIND_OPEN;
        if (!sts_i.emit_open || out_ready_i) state_d = ST_OPOLL;
      end
      ST_OPOLL: begin
        out_valid_o = sts_i.emit_poll;
        out_kind_o  = KIND_POLL;
        if (!sts_i.emit_poll || out_ready_i) state_d = ST_OSET;
      end
      ST_OSET: begin
        out_valid_o = (sts_i.set_kind != SET_NONE);
        out_kind_o  = (sts_i.set_kind == SET_BAL) ? KIND_SETBAL : KIND_SETMON;
        if (!out_valid_o || out_ready_i) state_d = ST_OSTAT;
      end
      ST_OSTAT: begin
        out_valid_o = 1'b1;
        out_kind_o  = KIND_STATUS;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `BPS_ASSERT_NOW(a_no_overlap, in_ready_o, !out_valid_o)
  `BPS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `BPS_ASSERT_NEXT(a_idle_after_status,
                   out_valid_o && out_ready_i && (out_kind_o == KIND_STATUS), in_ready_o)

endmodule

`default_nettype wire

### hdl/battery_pack_supervisor_top.sv
// battery pack supervisor: one item in, one to three result words out.
// s_axis carries an item (tuser = func), m_axis carries results (tuser = kind,
// tlast on the closing status word). cfg_* writes the eight limit registers.
// one item is handled at a time; s_axis_tready is high only while idle.
// a tick walks the module table (stopping at the first timed-out module), then
// scans the cell memory with one read per cycle; a report passes through two
// update steps; a mode request scans the cell memory only when balancing is
// asked for. each item then steps through the result kinds in order, emitting
// a word for each kind that applies and skipping the others.
// each result word is held on m_axis until taken; a stalled receiver holds
// the block, and the next item waits.
// reset clears the module table, the per-cell valid bits (cells read as zero
// until written), all status and timing registers, and loads the default
// limits. cfg_ready_o is always high; write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module battery_pack_supervisor_top #(
  parameter int NUM_MODULES = bps_pkg::NUM_MODULES_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // now_ms[31:0] source_addr[39:32] report_cmd[47:40] payload_len[51:48]
  // word_a[67:52] word_b[83:68] word_c[99:84] want_balance[100]
  input  wire [103:0]                  s_axis_tdata,
  // func[1:0]
  input  wire [1:0]                    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // poll_cmd[7:0] target_mv[23:8] error_latched[24] connected[29:25]
  output logic [31:0]                  m_axis_tdata,
  // kind[2:0]
  output logic [2:0]                   m_axis_tuser,
  output logic                         m_axis_tlast,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [bps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [15:0]                   cfg_data_i
);
  import bps_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  kind_e       kind;
  logic [7:0]  pcmd;
  logic [15:0] tgt;
  logic        err;
  logic [4:0]  conn;

  assign cfg_ready_o = 1'b1;

  bps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (kind),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bps_datapath #(
    .NUM_MODULES (NUM_MODULES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i),
    .cfg_idx_i       (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (s_axis_tuser),
    .now_ms_i        (s_axis_tdata[31:0]),
    .source_addr_i   (s_axis_tdata[39:32]),
    .report_cmd_i    (s_axis_tdata[47:40]),
    .payload_len_i   (s_axis_tdata[51:48]),
    .word_a_i        (s_axis_tdata[67:52]),
    .word_b_i        (s_axis_tdata[83:68]),
    .word_c_i        (s_axis_tdata[99:84]),
    .want_balance_i  (s_axis_tdata[100]),
    .poll_cmd_o      (pcmd),
    .target_mv_o     (tgt),
    .error_latched_o (err),
    .connected_o     (conn)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tlast = (kind == KIND_STATUS);
  assign m_axis_tdata = {2'b00, conn, err,
                         (kind == KIND_SETBAL) ? tgt : 16'd0,
                         (kind == KIND_POLL) ? pcmd : 8'd0};

endmodule

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for battery_pack_supervisor_top
// predicts result words with its own pack model; needs hdl/bps_pkg.sv and the rtl
`timescale 1ns / 1ps

import bps_pkg::*;

typedef struct packed {
  logic [2:0]  kind;
  logic [7:0]  poll_cmd;
  logic [15:0] target_mv;
  logic        err;
  logic [4:0]  conn;
  logic        last;
} pack_word_t;

class pack_scoreboard;
  logic [15:0] limit [NUM_CFG];
  logic [2:0]  mode [24];
  logic [31:0] seen [24];
  logic [15:0] cell_v [192];
  logic [15:0] res_max, cell_temp_max, bal_target;
  logic [4:0]  conn_cnt;
  logic        fault_flag, bal_mode;
  logic [31:0] open_next, poll_next;
  logic [1:0]  poll_idx;
  pack_word_t  pending [$];
  int          errors, words, items;

  function void clear();
    for (int i = 0; i < 24; i++) begin
      mode[i] = MODE_NOCOMM;
      seen[i] = '0;
    end
    foreach (cell_v[i]) cell_v[i] = '0;
    for (int i = 0; i < NUM_CFG; i++) limit[i] = CFG_RESET[i];
    res_max = 0; cell_temp_max = 0; bal_target = 0; conn_cnt = 0;
    fault_flag = 0; bal_mode = 0; open_next = 0; poll_next = 0; poll_idx = 0;
  endfunction

  function void push(kind_e k, logic [7:0] p, logic [15:0] t);
    pack_word_t w;
    w = '{kind: k, poll_cmd: p, target_mv: t, err: 0, conn: 0, last: 0};
    pending.push_back(w);
  endfunction

  // note an accepted item and queue its expected words
  function void note_item(func_e fn, logic [103:0] d);
    logic [31:0] now;
    logic [7:0]  src, rcmd;
    logic [3:0]  len;
    logic [15:0] wa, wb, wc, mn, mx;
    logic        fault, poll;
    logic [7:0]  pcmd;
    set_e        sk;
    int          id, base, cnt, first;
    now = d[31:0]; src = d[39:32]; rcmd = d[47:40]; len = d[51:48];
    wa = d[67:52]; wb = d[83:68]; wc = d[99:84];
    fault = 0; poll = 0; pcmd = 0; sk = SET_NONE;
    items++;
    if (fn == FUNC_TICK) begin
      cnt = 0;
      for (int i = 0; i < 24; i++) begin
        if (mode[i] != MODE_NOCOMM && seen[i] + {16'd0, limit[CFG_TIMEOUT]} < now) begin
          mode[i] = MODE_NOCOMM;
          fault = 1;
          break;
        end
        if (is_conn(mode[i])) cnt++;
      end
      conn_cnt = cnt[4:0];
      mn = 16'hFFFF; mx = 0;
      foreach (cell_v[i]) begin
        if (cell_v[i] < mn) mn = cell_v[i];
        if (cell_v[i] > mx) mx = cell_v[i];
      end
      if (mn < limit[CFG_CELL_MIN] || mx > limit[CFG_CELL_MAX]) fault = 1;
    end else if (fn == FUNC_REPORT) begin
      if (src >= ADDR_BASE && src < ADDR_BASE + 24) begin
        id = src - ADDR_BASE;
        seen[id] = now;
        if (rcmd == RPT_TEMP && len >= 2) begin
          if (res_max < wa) begin
            res_max = wa;
            if (wa > limit[CFG_RES_TEMP]) begin
              bal_mode = 0;
              if ({1'b0, wa} > {1'b0, limit[CFG_RES_TEMP]} + {1'b0, limit[CFG_RES_HARD]})
                fault = 1;
            end
          end
        end else if ((rcmd == RPT_STATE_A || rcmd == RPT_STATE_B) && len >= 2) begin
          mode[id] = (mode[id] == MODE_NOCOMM) ? MODE_CONNECTING : wa[2:0];
          if (mode[id] == MODE_PROBLEM) fault = 1;
          if (!bal_mode && mode[id] == MODE_BALANCE) sk = SET_MON;
          else if (bal_mode && mode[id] == MODE_MONITOR) sk = SET_BAL;
        end else if ((rcmd == RPT_CELL_LO && len >= 6) || (rcmd == RPT_CELL_HI && len >= 2)) begin
          base = id * 8 + ((rcmd == RPT_CELL_HI) ? 4 : 0);
          if (wa == 0) begin
            cell_v[base] = wb; cell_v[base + 1] = wc;
            if (wc > cell_temp_max) cell_temp_max = wc;
            if (cell_temp_max > limit[CFG_CELL_TEMP]) fault = 1;
          end else begin
            cell_v[base + 2] = wb; cell_v[base + 3] = wc;
          end
        end
      end
    end else if (fn == FUNC_MODE) begin
      if (d[100]) begin
        mn = 16'hFFFF;
        foreach (cell_v[i]) if (is_conn(mode[i / 8]) && cell_v[i] < mn) mn = cell_v[i];
        if (mn != 16'hFFFF && mn > limit[CFG_BAL_START]) begin
          bal_target = mn; bal_mode = 1; sk = SET_BAL;
        end
      end else begin
        bal_mode = 0; sk = SET_MON;
      end
    end
    first = pending.size();
    if (fault) begin
      fault_flag = 1;
      if (open_next < now) begin
        open_next = now + limit[CFG_PERIOD];
        push(KIND_OPEN, 0, 0);
      end
    end
    if (fn == FUNC_TICK && poll_next < now) begin
      poll_next = now + limit[CFG_PERIOD];
      pcmd = POLL_BASE + poll_idx;
      poll_idx++;
      push(KIND_POLL, pcmd, 0);
    end
    if (sk == SET_BAL) push(KIND_SETBAL, 0, bal_target);
    else if (sk == SET_MON) push(KIND_SETMON, 0, 0);
    push(KIND_STATUS, 0, 0);
    for (int k = first; k < pending.size(); k++) begin
      pending[k].err = fault_flag;
      pending[k].conn = conn_cnt;
      pending[k].last = (k == pending.size() - 1);
    end
  endfunction

  function void check_word(pack_word_t got);
    pack_word_t exp_w;
    words++;
    if (pending.size() == 0) begin
      $error("result word with nothing expected: kind %0d", got.kind);
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (got.kind != exp_w.kind) begin
      $error("kind: expected %0d, got %0d", exp_w.kind, got.kind); errors++;
    end
    if (got.poll_cmd != exp_w.poll_cmd) begin
      $error("poll_cmd: expected %h, got %h", exp_w.poll_cmd, got.poll_cmd); errors++;
    end
    if (got.target_mv != exp_w.target_mv) begin
      $error("target_mv: expected %0d, got %0d", exp_w.target_mv, got.target_mv); errors++;
    end
    if (got.err != exp_w.err) begin
      $error("error_latched: expected %0d, got %0d", exp_w.err, got.err); errors++;
    end
    if (got.conn != exp_w.conn) begin
      $error("connected: expected %0d, got %0d", exp_w.conn, got.conn); errors++;
    end
    if (got.last != exp_w.last) begin
      $error("last: expected %0d, got %0d", exp_w.last, got.last); errors++;
    end
  endfunction
endclass

module testbench;
  logic         clk_i = 0, rst_ni = 0;
  logic         s_axis_tvalid = 0, s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [31:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_valid_i = 0, cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;

  pack_scoreboard pack = new();
  int  send_idle = 0, recv_idle = 0, quiet = 0;
  logic [31:0] clock_ms = 1000;

  battery_pack_supervisor_top dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // receiver: random stall, check each taken word
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      pack.check_word('{kind: m_axis_tuser, poll_cmd: m_axis_tdata[7:0],
                        target_mv: m_axis_tdata[23:8], err: m_axis_tdata[24],
                        conn: m_axis_tdata[29:25], last: m_axis_tlast});
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet > 20000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end
  always @(negedge clk_i) m_axis_tready <= !rst_ni ? 0 : ($urandom_range(99) >= recv_idle);

  task automatic write_limit(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    pack.limit[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic send_item(func_e fn, logic [31:0] now, logic [7:0] src, logic [7:0] rcmd,
                           logic [3:0] len, logic [15:0] wa, wb, wc, logic bal);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    s_axis_tvalid <= 1; s_axis_tuser <= fn;
    s_axis_tdata <= {3'b0, bal, wc, wb, wa, len, rcmd, src, now};
    do @(posedge clk_i); while (!s_axis_tready);
    pack.note_item(fn, {3'b0, bal, wc, wb, wa, len, rcmd, src, now});
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pack.pending.size() != 0 && guard < 100000) begin
      @(posedge clk_i); guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  // mostly well-formed reports from live modules, with ticks and mode requests
  task automatic random_item();
    int    r;
    logic [7:0] src, rcmd;
    logic [15:0] wa;
    r = $urandom_range(99);
    clock_ms += $urandom_range(3) == 0 ? $urandom_range(400) : $urandom_range(40);
    src = 8'(ADDR_BASE + $urandom_range(5));
    if ($urandom_range(9) == 0) src = 8'($urandom);
    if (r < 20)
      send_item(FUNC_TICK, clock_ms, 8'($urandom), 8'($urandom), 4'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    else if (r < 80) begin
      case ($urandom_range(4))
        0: rcmd = RPT_TEMP;
        1: rcmd = RPT_CELL_LO;
        2: rcmd = RPT_CELL_HI;
        3: rcmd = $urandom_range(1) ? RPT_STATE_A : RPT_STATE_B;
        default: rcmd = 8'($urandom);
      endcase
      wa = (rcmd == RPT_CELL_LO || rcmd == RPT_CELL_HI) ? 16'($urandom_range(1)) :
           (rcmd == RPT_TEMP) ? 16'($urandom_range(1000)) : 16'($urandom_range(7));
      if ($urandom_range(15) == 0) wa = 16'($urandom);
      send_item(FUNC_REPORT, clock_ms, src, rcmd,
                $urandom_range(9) ? 4'd8 : 4'($urandom_range(15)),
                wa, 16'(3000 + $urandom_range(600)), 16'(3000 + $urandom_range(600)), 0);
    end else if (r < 95)
      send_item(FUNC_MODE, clock_ms, 0, 0, 0, 0, 0, 0, $urandom_range(2) != 0);
    else
      send_item(FUNC_NOP, $urandom, 8'($urandom), 8'($urandom), 4'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  initial begin
    pack.clear();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;

    // directed: join modules, cells, temps, balance, faults, edges
    send_item(FUNC_NOP, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    for (int m = 0; m < 2; m++) begin
      send_item(FUNC_REPORT, 100, 8'(ADDR_BASE + m), RPT_STATE_A, 2, 16'(MODE_MONITOR),
                0, 0, 0);
      send_item(FUNC_REPORT, 110, 8'(ADDR_BASE + m), RPT_STATE_B, 2, 16'(MODE_MONITOR),
                0, 0, 0);
    end
    send_item(FUNC_REPORT, 120, ADDR_BASE, RPT_CELL_LO, 6, 0, 3300, 3400, 0);
    send_item(FUNC_REPORT, 121, ADDR_BASE, RPT_CELL_LO, 5, 1, 3300, 3400, 0);
    send_item(FUNC_REPORT, 122, ADDR_BASE, RPT_CELL_HI, 2, 1, 16'hFFFF, 0, 0);
    send_item(FUNC_MODE, 130, 0, 0, 0, 0, 0, 0, 1);
    send_item(FUNC_REPORT, 140, 8'(ADDR_BASE + 1), RPT_STATE_A, 2, 16'hFFFA, 0, 0, 0);
    send_item(FUNC_REPORT, 141, 8'(ADDR_BASE + 1), RPT_STATE_A, 2, 16'(MODE_BALANCE),
              0, 0, 0);
    send_item(FUNC_REPORT, 150, ADDR_BASE, RPT_TEMP, 2, 16'hFFFF, 0, 0, 0);
    send_item(FUNC_REPORT, 151, ADDR_BASE, RPT_STATE_A, 2, 16'(MODE_PROBLEM), 0, 0, 0);
    send_item(FUNC_REPORT, 152, 8'(ADDR_BASE + 23), RPT_STATE_A, 2, 0, 0, 0, 0);
    send_item(FUNC_REPORT, 153, 8'(ADDR_BASE + 24), RPT_STATE_A, 2, 0, 0, 0, 0);
    send_item(FUNC_REPORT, 154, 8'hFF, RPT_TEMP, 15, 0, 0, 0, 0);
    send_item(FUNC_MODE, 160, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_TICK, 5000, 0, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_TICK, 5001, 0, 0, 0, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 10 : (ph == 1) ? 47 : 0;
      recv_idle = (ph == 0) ? 47 : (ph == 1) ? 10 : 0;
      for (int i = 0; i < 8; i++)
        write_limit(i[2:0], ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0000 : 16'($urandom));
      if (ph == 2) begin
        write_limit(CFG_CELL_MIN, 2900);
        write_limit(CFG_CELL_MAX, 3700);
        write_limit(CFG_TIMEOUT, 300);
        write_limit(CFG_PERIOD, 100);
      end
      repeat (115) random_item();
      drain();
    end

    $display("covered %0d items and %0d result words over three limit settings",
             pack.items, pack.words);
    if (pack.errors == 0 && pack.pending.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule
